// ----- design/cma_pkg.sv -----
// Shared constants, codes and types for the covariance matrix accumulator.
// Used by the accumulator store, the divider and the top level.
package cma_pkg;

    // Matrix size and row limit
    localparam int COLUMNS  = 16;
    localparam int MAX_ROWS = 4096;

    // Field and storage widths
    localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ADDR_W   = 2 * COL_W;
    localparam int DEPTH    = COLUMNS * COLUMNS;
    localparam int ACC_W    = 48;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ROW_W    = $clog2(MAX_ROWS + 1);
    localparam int CFG_W    = 5;
    localparam int IDX_W    = 4;
    localparam int CMP_W    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int STEP_W   = $clog2(ACC_W);

    // Dimension register reset value
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // Operation codes of an input word
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DRAIN,
        S_RDWAIT,
        S_DIV,
        S_RES
    } state_t;

endpackage

// ----- design/cma_acc_store.sv -----
// Accumulator store: COLUMNS x COLUMNS sums in a synchronous memory.
// Per-entry valid bits let a clear drop every entry at once; invalid entries read as zero.
// Depends on cma_pkg.
module cma_acc_store
    import cma_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ACC_W-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ACC_W-1:0]  wr_data
);

    logic [ACC_W-1:0] mem_reg [DEPTH];
    logic [ACC_W-1:0] rd_mem_reg;
    logic             rd_vld_reg;
    logic [DEPTH-1:0] vld_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem_reg[rd_addr];
    end

    // Track written entries; clear drops them all at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
            if (clear)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

endmodule

// ----- design/cma_divider.sv -----
// Iterative signed divider: one quotient bit per cycle, truncates toward zero.
// Divides an ACC_W-bit sum by an unsigned ROW_W-bit nonzero count. Depends on cma_pkg.
module cma_divider
    import cma_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ACC_W-1:0] dividend,
    input  logic [ROW_W-1:0] divisor,
    output logic             done,
    output logic [ACC_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ACC_W-1:0]  dvd_reg;
    logic [ROW_W-1:0]  rem_reg;
    logic [ROW_W-1:0]  den_reg;
    logic [ROW_W:0]    shifted;
    logic              fits;

    // Trial subtraction for the next quotient bit
    assign shifted = {rem_reg, dvd_reg[ACC_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ACC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load magnitudes, then shift in one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[ACC_W-1];
            dvd_reg <= dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? ROW_W'(shifted - {1'b0, den_reg}) : shifted[ROW_W-1:0];
            dvd_reg <= {dvd_reg[ACC_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~dvd_reg + ACC_W'(1)) : dvd_reg;

endmodule

// ----- design/covariance_matrix_accumulator.sv -----
// Covariance matrix accumulator top level: control sequencer, row buffer,
// multiply stage and output register. Uses cma_pkg, cma_acc_store, cma_divider.
//
// Input channel (in_valid/in_ready) takes one word: op, sample, entry_row,
// entry_col. An add word places the sample at the current column j and adds
// sample*x_k into sums (j,k) for k = 0..j, one read-modify-write per cycle in
// the accumulator memory; in_ready returns after the walk and a drain state.
// Once MAX_ROWS rows are complete an add is dropped without a walk and the
// sticky drop flag is set. A clear word empties the store and counters. A read
// word fetches entry (i,j), mirrored for i<j, and divides it by rows-1 in a
// one-bit-per-cycle divider via the read-wait, divide and result states, or
// goes straight to the result state when too few rows exist or the index lies
// outside the matrix (value zero). Output channel (out_valid/out_ready) is a
// register; a stalled receiver holds it, and the block keeps taking add and
// clear words meanwhile, but a finished read waits until the register frees.
// cfg_we/cfg_wdata write the dimension register; the user must write it only
// while the block is idle; the block does not enforce it. Reset (rst_n low)
// empties the store at once, zeroes the counters and sets the dimension to 16.
module covariance_matrix_accumulator
    import cma_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [IDX_W-1:0]           entry_row,
    input  logic [IDX_W-1:0]           entry_col,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [ACC_W-1:0]    covariance,
    output logic                       too_few_rows,
    output logic                       samples_dropped
);

    state_t state_reg;
    state_t state_next;

    logic [CFG_W-1:0]           cols_reg;
    logic [COL_W-1:0]           pos_reg;
    logic [ROW_W-1:0]           row_count_reg;
    logic                       drop_reg;
    logic signed [SAMPLE_W-1:0] row_buf_reg [COLUMNS];
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [COL_W-1:0]           j_reg;
    logic [COL_W-1:0]           k_reg;
    logic                       wr_pend_reg;
    logic [ADDR_W-1:0]          wr_addr_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       few_reg;
    logic                       zero_reg;
    logic                       out_valid_reg;
    logic [ACC_W-1:0]           cov_reg;
    logic                       few_out_reg;
    logic                       drop_out_reg;

    logic              accept;
    op_t               op_in;
    logic [CMP_W-1:0]  m_eff;
    logic [IDX_W-1:0]  idx_hi;
    logic [IDX_W-1:0]  idx_lo;
    logic              in_range;
    logic              few;
    logic              full;
    logic              row_end;
    logic [ADDR_W-1:0] rd_addr;
    logic [ACC_W-1:0]  store_rd;
    logic [ACC_W-1:0]  store_wr;
    logic              store_clear;
    logic              div_start;
    logic              div_done;
    logic [ACC_W-1:0]  div_quot;
    logic              out_load;

    // Decode the input word and the current dimension
    assign accept = in_valid && in_ready;
    assign op_in  = op_t'(op);

    always_comb
    begin
        m_eff = CMP_W'(cols_reg);
        if (m_eff < CMP_W'(2))
        begin
            m_eff = CMP_W'(2);
        end
        if (m_eff > CMP_W'(COLUMNS))
        begin
            m_eff = CMP_W'(COLUMNS);
        end
    end

    assign idx_hi   = (entry_row >= entry_col) ? entry_row : entry_col;
    assign idx_lo   = (entry_row >= entry_col) ? entry_col : entry_row;
    assign in_range = CMP_W'(idx_hi) < m_eff;
    assign few      = row_count_reg < ROW_W'(2);
    assign full     = row_count_reg == ROW_W'(MAX_ROWS);
    assign row_end  = (CMP_W'(pos_reg) + CMP_W'(1)) >= m_eff;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        OP_ADD:
                        begin
                            if (!full)
                            begin
                                state_next = S_ADD;
                            end
                        end
                        OP_READ:
                        begin
                            state_next = (few || !in_range) ? S_RES : S_RDWAIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (k_reg == j_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            S_RDWAIT:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready    = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        store_clear = 1'b0;
        rd_addr     = {j_reg, k_reg};
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                store_clear = in_valid && (op_in == OP_CLEAR);
                rd_addr     = {COL_W'(idx_hi), COL_W'(idx_lo)};
            end
            S_RDWAIT:
            begin
                div_start = 1'b1;
            end
            S_RES:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                rd_addr = {j_reg, k_reg};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Dimension register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cols_reg <= cfg_wdata;
        end
    end

    // Advance column position and row count; clear or set the drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            row_count_reg <= '0;
            drop_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (op_in == OP_CLEAR)
            begin
                pos_reg       <= '0;
                row_count_reg <= '0;
                drop_reg      <= 1'b0;
            end
            else if (op_in == OP_ADD)
            begin
                if (full)
                begin
                    drop_reg <= 1'b1;
                end
                else if (row_end)
                begin
                    pos_reg       <= '0;
                    row_count_reg <= row_count_reg + ROW_W'(1);
                end
                else
                begin
                    pos_reg <= pos_reg + COL_W'(1);
                end
            end
        end
    end

    // Hold the sample in the row buffer and latch the read flags
    always_ff @(posedge clk)
    begin
        if (accept && (op_in == OP_ADD) && !full)
        begin
            row_buf_reg[pos_reg] <= sample;
            x_reg                <= sample;
            j_reg                <= pos_reg;
        end
        if (accept && (op_in == OP_READ))
        begin
            few_reg  <= few;
            zero_reg <= few || !in_range;
        end
    end

    // Column walk over k = 0..j
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (accept)
        begin
            k_reg <= '0;
        end
        else if ((state_reg == S_ADD) && (k_reg != j_reg))
        begin
            k_reg <= k_reg + COL_W'(1);
        end
    end

    // Multiply stage alongside the memory read; write back next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= state_reg == S_ADD;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD)
        begin
            wr_addr_reg <= {j_reg, k_reg};
            prod_reg    <= x_reg * row_buf_reg[k_reg];
        end
    end

    assign store_wr = store_rd + ACC_W'(prod_reg);

    cma_acc_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (store_clear),
        .rd_addr (rd_addr),
        .rd_data (store_rd),
        .wr_en   (wr_pend_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (store_wr)
    );

    cma_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (store_rd),
        .divisor  (row_count_reg - ROW_W'(1)),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Output register: load a finished read, drop valid when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cov_reg      <= zero_reg ? '0 : div_quot;
            few_out_reg  <= few_reg;
            drop_out_reg <= drop_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign covariance      = cov_reg;
    assign too_few_rows    = few_out_reg;
    assign samples_dropped = drop_out_reg;

    // A memory write only follows a read issued by the column walk
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> $past(state_reg == S_ADD))
        else $error("accumulator write without a preceding column read");

    // The drop flag only rises once the row limit has been reached
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(drop_reg) |-> $past(row_count_reg == ROW_W'(MAX_ROWS)))
        else $error("samples dropped below the row limit");

    // The column walk never passes the sample's own column
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |-> (k_reg <= j_reg))
        else $error("column walk passed the current column");

    // The divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

endmodule

// ----- dv/tb_covariance_matrix_accumulator.sv -----
// Testbench for covariance_matrix_accumulator: directed and random traffic
// checked against an in-bench mirror of the accumulator. Depends on cma_pkg and the RTL.
module tb_covariance_matrix_accumulator;
    import cma_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_CHUNK  = 194;

    // One covariance word as the output channel carries it
    typedef struct {
        logic signed [ACC_W-1:0] value;
        logic                    few;
        logic                    dropped;
    } cov_word_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_W-1:0]           cfg_wdata;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           entry_row;
    logic [IDX_W-1:0]           entry_col;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [ACC_W-1:0]    covariance;
    logic                       too_few_rows;
    logic                       samples_dropped;

    // Mirror of the accumulator state
    logic signed [ACC_W-1:0]    sum_copy [DEPTH];
    logic signed [SAMPLE_W-1:0] row_copy [COLUMNS];
    int                         col_pos;
    int                         rows_done;
    logic                       drop_seen;
    logic [CFG_W-1:0]           dim_setting;

    cov_word_t covariance_due[$];
    int        mismatches;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    covariance_matrix_accumulator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .sample          (sample),
        .entry_row       (entry_row),
        .entry_col       (entry_col),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .covariance      (covariance),
        .too_few_rows    (too_few_rows),
        .samples_dropped (samples_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Receiver: stall at random per the current idling mode
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic flag_mismatch(input string msg);
        if (mismatches < 100)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Compare each result word with the oldest pending one
    always @(posedge clk)
    begin
        cov_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (covariance_due.size() == 0)
                flag_mismatch("result word with none pending");
            else
            begin
                want = covariance_due.pop_front();
                if (covariance !== want.value)
                    flag_mismatch($sformatf("covariance got %0d want %0d",
                                            covariance, want.value));
                if (too_few_rows !== want.few)
                    flag_mismatch($sformatf("too_few_rows got %0b want %0b",
                                            too_few_rows, want.few));
                if (samples_dropped !== want.dropped)
                    flag_mismatch($sformatf("samples_dropped got %0b want %0b",
                                            samples_dropped, want.dropped));
            end
        end
    end

    function automatic int dim_now();
        int m;
        m = dim_setting;
        if (m < 2)
            m = 2;
        if (m > COLUMNS)
            m = COLUMNS;
        return m;
    endfunction

    task automatic clear_sums();
        foreach (sum_copy[a])
            sum_copy[a] = '0;
        col_pos   = 0;
        rows_done = 0;
        drop_seen = 1'b0;
    endtask

    // Update the mirror with one accepted word; queue the covariance a read returns
    task automatic fold_word(input op_t o, input logic signed [SAMPLE_W-1:0] s,
                             input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
        int                      m;
        int                      j;
        int                      k;
        int                      hi;
        int                      lo;
        logic signed [PROD_W-1:0] prod;
        longint                  total;
        cov_word_t               res;
        m = dim_now();
        case (o)
            OP_ADD:
            begin
                if (rows_done >= MAX_ROWS)
                    drop_seen = 1'b1;
                else
                begin
                    j = (col_pos >= COLUMNS) ? COLUMNS - 1 : col_pos;
                    row_copy[j] = s;
                    for (k = 0; k <= j; k++)
                    begin
                        prod = s * row_copy[k];
                        sum_copy[j * COLUMNS + k] = sum_copy[j * COLUMNS + k] + prod;
                    end
                    // A position at or past the last column ends the row
                    if (j + 1 >= m)
                    begin
                        col_pos = 0;
                        rows_done++;
                    end
                    else
                        col_pos = j + 1;
                end
            end
            OP_READ:
            begin
                hi = r;
                lo = c;
                if (hi < lo)
                begin
                    hi = c;
                    lo = r;
                end
                res.few     = (rows_done < 2);
                res.dropped = drop_seen;
                res.value   = '0;
                if (!res.few && hi < m)
                begin
                    total     = sum_copy[hi * COLUMNS + lo];
                    total     = total / longint'(rows_done - 1);
                    res.value = total[ACC_W-1:0];
                end
                covariance_due.push_back(res);
            end
            OP_CLEAR:
                clear_sums();
            default:
            begin
            end
        endcase
    endtask

    // Present one word and hold it until taken; returns at the next falling edge
    task automatic send_word(input op_t o, input logic signed [SAMPLE_W-1:0] s,
                             input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        op        = o;
        sample    = s;
        entry_row = r;
        entry_col = c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        fold_word(o, s, r, c);
        @(negedge clk);
    endtask

    task automatic add_word(input logic signed [SAMPLE_W-1:0] s);
        send_word(OP_ADD, s, IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic read_word(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
        send_word(OP_READ, SAMPLE_W'($urandom), r, c);
    endtask

    // Drop valid, wait for every pending result, then let the block go quiet
    task automatic settle();
        in_valid = 1'b0;
        while (covariance_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_dimension(input logic [CFG_W-1:0] v);
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we      = 1'b0;
        dim_setting = v;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(19))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic apply_reset();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        dim_setting = CFG_RESET;
        foreach (row_copy[a])
            row_copy[a] = '0;
        clear_sums();
    endtask

    // Extremes, every op, mirrored and outside reads, shrinking the dimension mid-row
    task automatic test_directed();
        set_idling(0, 0);
        read_word(4'd0, 4'd0);
        settle();
        write_dimension(5'd3);
        add_word(16'sh7FFF);
        add_word(16'sh8000);
        add_word('0);
        read_word(4'd1, 4'd0);
        add_word(16'sh8000);
        add_word(16'sh8000);
        add_word(16'sh0001);
        read_word(4'd0, 4'd0);
        read_word(4'd0, 4'd1);
        read_word(4'd2, 4'd1);
        read_word(4'd3, 4'd1);
        read_word(4'd15, 4'd15);
        send_word(OP_NOP, 16'sh7FFF, 4'd15, 4'd15);
        add_word(16'sh0005);
        add_word(-16'sh0007);
        settle();
        write_dimension(5'd2);
        add_word(16'sh012C);
        read_word(4'd2, 4'd2);
        read_word(4'd1, 4'd1);
        read_word(4'd0, 4'd1);
        send_word(OP_CLEAR, '0, 4'd0, 4'd0);
        read_word(4'd0, 4'd0);
        settle();
    endtask

    task automatic send_random_word();
        int               pick;
        int               m;
        op_t              o;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        m    = dim_now();
        pick = $urandom_range(999);
        r    = IDX_W'($urandom);
        c    = IDX_W'($urandom);
        if (pick < 8)
            o = OP_CLEAR;
        else if (pick < 25)
            o = OP_NOP;
        else if (pick < 275)
        begin
            o = OP_READ;
            // mostly inside the matrix, some anywhere
            if ($urandom_range(4) != 0)
            begin
                r = IDX_W'($urandom_range(m - 1));
                c = IDX_W'($urandom_range(m - 1));
            end
        end
        else
            o = OP_ADD;
        send_word(o, pick_sample(), r, c);
    endtask

    // Random rows across dimension settings and idling modes
    task automatic test_random_traffic();
        logic [CFG_W-1:0] dims [8];
        int               chunk;
        dims = '{5'd16, 5'd2, 5'd0, 5'd7, 5'd31, 5'd12, 5'd3, 5'd16};
        for (chunk = 0; chunk < 8; chunk++)
        begin
            settle();
            write_dimension(dims[chunk]);
            case (chunk % 4)
                0: set_idling(0, 0);
                1: set_idling(57, 0);
                2: set_idling(0, 57);
                default: set_idling(12, 12);
            endcase
            repeat (RANDOM_CHUNK) send_random_word();
        end
        settle();
    endtask

    initial
    begin
        mismatches = 0;
        in_valid   = 1'b0;
        op         = OP_NOP;
        sample     = '0;
        entry_row  = '0;
        entry_col  = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        set_idling(0, 0);
        apply_reset();
        test_directed();
        test_random_traffic();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- covariance_matrix_accumulator.f -----
design/cma_pkg.sv
design/cma_acc_store.sv
design/cma_divider.sv
design/covariance_matrix_accumulator.sv
dv/tb_covariance_matrix_accumulator.sv
